@@ design/csort_pkg.sv @@
// shared types and constants for the card sorter
package csort_pkg;
    localparam int MaxCardsDefault = 32;
    localparam int CardWidth = 16;

    typedef struct packed {
        logic [7:0] card_suit;
        logic [7:0] card_value;
        logic       last_card;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_suit;
        logic [7:0] out_value;
        logic       is_stable;
        logic       last_out;
    } out_beat_t;

    localparam logic SortBubble = 1'b0;
    localparam logic SortSelect = 1'b1;
endpackage

@@ design/card_sort_with_stability_check.sv @@
// card sorter top level: load, sort in ram, stability check, emit
//
//  channel | dir | payload        | handshake
//  in      | in  | in_beat_t      | in_valid / in_ready
//  out     | out | out_beat_t     | out_valid / out_ready
//  cfg     | in  | sort_method    | cfg_valid / cfg_ready
//
// loading accepts one card per cycle, then the cards are copied into the sorted ram;
// bubble sort swaps adjacent cards, selection sort swaps the minimum in once per pass
// the check compares every pair of cards; an equal-value pair adds two sweeps of the
// sorted ram to locate both cards; input and config wait from the last card
// until the last result is accepted. reset clears control only, rams stay undefined
module card_sort_with_stability_check #(
    parameter int MaxCards = csort_pkg::MaxCardsDefault
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  csort_pkg::in_beat_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output csort_pkg::out_beat_t out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data
);
    localparam int AW = $clog2(MaxCards);
    localparam int CW = $clog2(MaxCards + 1);

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_COPY  = 11'b00000000010,
        S_RDA   = 11'b00000000100,
        S_RDB   = 11'b00000001000,
        S_CMP   = 11'b00000010000,
        S_SWAP  = 11'b00000100000,
        S_CKI   = 11'b00001000000,
        S_CKJ   = 11'b00010000000,
        S_FPOS  = 11'b00100000000,
        S_EMIT  = 11'b01000000000,
        S_WAIT  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic method_reg;
    logic [CW-1:0] n_reg;
    logic [AW-1:0] i_reg, j_reg, m_reg, p_reg;
    logic [CW-1:0] cnt_reg;
    logic [15:0] a_reg, b_reg, ci_reg, cj_reg;
    logic [CW-1:0] pos_i_reg;
    logic fp_second_reg;
    logic stable_reg;
    logic [1:0] ph_reg;

    // original ram
    logic          o_we;
    logic [AW-1:0] o_waddr, o_raddr;
    logic [15:0]   o_wdata, o_rdata;
    // sorted ram
    logic          s_we;
    logic [AW-1:0] s_waddr, s_raddr;
    logic [15:0]   s_wdata, s_rdata;

    csort_ram #(.Width(csort_pkg::CardWidth), .Depth(MaxCards)) u_orig (
        .clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
        .raddr(o_raddr), .rdata(o_rdata));
    csort_ram #(.Width(csort_pkg::CardWidth), .Depth(MaxCards)) u_sort (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata));

    assign cfg_ready  = (state_reg == S_LOAD);
    assign in_ready   = (state_reg == S_LOAD);

    logic [AW-1:0] last_idx;
    assign last_idx = AW'(n_reg - CW'(1));

    // sequencer: each step reads both rams and may write one of them
    always_comb
    begin
        state_next = state_reg;
        o_we = 1'b0; o_waddr = cnt_reg[AW-1:0];
        o_wdata = {in_data.card_suit, in_data.card_value};
        o_raddr = i_reg;
        s_we = 1'b0; s_waddr = j_reg; s_wdata = o_rdata; s_raddr = j_reg;
        case (state_reg)
            S_LOAD:
            begin
                o_we = in_valid;
            end
            S_COPY:
            begin
                o_raddr = p_reg;
                s_waddr = AW'(p_reg - AW'(1));
                s_we = (ph_reg != 2'd0);
            end
            S_RDA:   s_raddr = j_reg;
            S_RDB:   s_raddr = (method_reg == csort_pkg::SortBubble) ?
                               AW'(j_reg - AW'(1)) : m_reg;
            S_SWAP:
            begin
                if (method_reg == csort_pkg::SortBubble)
                begin
                    s_we = 1'b1;
                    s_waddr = (ph_reg == 2'd0) ? j_reg : AW'(j_reg - AW'(1));
                    s_wdata = (ph_reg == 2'd0) ? b_reg : a_reg;
                end
                else
                begin
                    // ph 2/3 read card i, ph 0/1 write both cards
                    s_we = (ph_reg == 2'd0) || (ph_reg == 2'd1);
                    s_raddr = i_reg;
                    s_waddr = (ph_reg == 2'd0) ? m_reg : i_reg;
                    s_wdata = (ph_reg == 2'd0) ? a_reg : b_reg;
                end
            end
            S_CKI:   o_raddr = (ph_reg == 2'd0) ? i_reg : j_reg;
            S_FPOS:  s_raddr = p_reg;
            S_EMIT:  s_raddr = p_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            method_reg <= csort_pkg::SortBubble;
            cnt_reg    <= '0;
            n_reg      <= '0;
            i_reg <= '0; j_reg <= '0; m_reg <= '0; p_reg <= '0;
            ph_reg <= '0;
            stable_reg <= 1'b1;
            fp_second_reg <= 1'b0;
            pos_i_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                method_reg <= cfg_data;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (in_valid)
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                        if (in_data.last_card || (cnt_reg + CW'(1)) == CW'(MaxCards))
                        begin
                            n_reg <= cnt_reg + CW'(1);
                            p_reg <= '0;
                            ph_reg <= '0;
                            state_reg <= S_COPY;
                        end
                    end
                end
                S_COPY:
                begin
                    // read p, write p-1 from last cycle's data
                    ph_reg <= 2'd1;
                    if (ph_reg != 2'd0 && AW'(p_reg - AW'(1)) == last_idx)
                    begin
                        i_reg <= '0;
                        stable_reg <= 1'b1;
                        if (n_reg == CW'(1))
                        begin
                            state_reg <= S_CKI; ph_reg <= '0;
                        end
                        else
                        begin
                            j_reg <= (method_reg == csort_pkg::SortBubble) ? last_idx : '0;
                            m_reg <= '0;
                            ph_reg <= '0;
                            state_reg <= S_RDA;
                        end
                    end
                    else
                    begin
                        p_reg <= p_reg + AW'(1);
                    end
                end
                S_RDA: state_reg <= S_RDB;
                S_RDB:
                begin
                    a_reg <= s_rdata;
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    b_reg <= s_rdata;
                    ph_reg <= '0;
                    if (method_reg == csort_pkg::SortBubble)
                    begin
                        // a = card j, b = card j-1
                        if (a_reg[7:0] < s_rdata[7:0]) state_reg <= S_SWAP;
                        else if (j_reg == AW'(i_reg + AW'(1)))
                        begin
                            if (CW'(i_reg) + CW'(2) == n_reg)
                            begin
                                state_reg <= S_CKI;
                                i_reg <= '0;
                            end
                            else
                            begin
                                state_reg <= S_RDA;
                                i_reg <= i_reg + AW'(1);
                            end
                            j_reg <= last_idx;
                        end
                        else
                        begin
                            j_reg <= j_reg - AW'(1);
                            state_reg <= S_RDA;
                        end
                    end
                    else
                    begin
                        // a = card j, b = card m (current minimum)
                        if (a_reg[7:0] < s_rdata[7:0]) m_reg <= j_reg;
                        if (j_reg == last_idx)
                        begin
                            state_reg <= S_SWAP;
                            if (a_reg[7:0] < s_rdata[7:0])
                            begin
                                m_reg <= j_reg;
                                b_reg <= a_reg;
                            end
                            ph_reg <= 2'd2;
                        end
                        else
                        begin
                            j_reg <= j_reg + AW'(1);
                            state_reg <= S_RDA;
                        end
                    end
                end
                S_SWAP:
                begin
                    if (method_reg == csort_pkg::SortBubble)
                    begin
                        ph_reg <= ph_reg + 2'd1;
                        if (ph_reg == 2'd1)
                        begin
                            ph_reg <= '0;
                            if (j_reg == AW'(i_reg + AW'(1)))
                            begin
                                if (CW'(i_reg) + CW'(2) == n_reg)
                                begin
                                    state_reg <= S_CKI;
                                    i_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= S_RDA;
                                    i_reg <= i_reg + AW'(1);
                                end
                                j_reg <= last_idx;
                            end
                            else
                            begin
                                j_reg <= j_reg - AW'(1);
                                state_reg <= S_RDA;
                            end
                        end
                    end
                    else
                    begin
                        // ph 2: issue read of card i; ph 3: latch it into a; ph 0/1 write
                        case (ph_reg)
                            2'd2:
                            begin
                                ph_reg <= 2'd3;
                            end
                            2'd3:
                            begin
                                a_reg <= s_rdata;
                                ph_reg <= 2'd0;
                            end
                            2'd0: ph_reg <= 2'd1;
                            default:
                            begin
                                ph_reg <= '0;
                                if (CW'(i_reg) + CW'(2) == n_reg)
                                begin
                                    state_reg <= S_CKI;
                                    i_reg <= '0;
                                end
                                else
                                begin
                                    state_reg <= S_RDA;
                                    i_reg <= i_reg + AW'(1);
                                end
                                m_reg <= i_reg + AW'(1);
                                j_reg <= i_reg + AW'(1);
                            end
                        endcase
                    end
                end
                S_CKI:
                begin
                    // ph 0: read i; ph 1: read j, latch i; ph 2: latch j
                    ph_reg <= ph_reg + 2'd1;
                    if (ph_reg == 2'd0 && CW'(i_reg) + CW'(1) >= n_reg)
                    begin
                        p_reg <= '0; ph_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                    else if (ph_reg == 2'd0) j_reg <= i_reg + AW'(1);
                    if (ph_reg == 2'd1) ci_reg <= o_rdata;
                    if (ph_reg == 2'd2)
                    begin
                        cj_reg <= o_rdata;
                        ph_reg <= '0;
                        state_reg <= S_CKJ;
                    end
                end
                S_CKJ:
                begin
                    if (ci_reg[7:0] == cj_reg[7:0])
                    begin
                        p_reg <= '0; ph_reg <= '0; fp_second_reg <= 1'b0;
                        state_reg <= S_FPOS;
                    end
                    else if (CW'(j_reg) + CW'(1) == n_reg)
                    begin
                        i_reg <= i_reg + AW'(1); ph_reg <= '0;
                        state_reg <= S_CKI;
                    end
                    else
                    begin
                        j_reg <= j_reg + AW'(1); ph_reg <= 2'd1;
                        state_reg <= S_CKI;
                    end
                end
                S_FPOS:
                begin
                    // sweep sorted ram; ph 0 issues address 0, ph 1 compares
                    ph_reg <= 2'd1;
                    if (ph_reg == 2'd1 && (s_rdata ==
                        (fp_second_reg ? cj_reg : ci_reg) ||
                        CW'(p_reg) == n_reg))
                    begin
                        ph_reg <= '0;
                        if (!fp_second_reg)
                        begin
                            pos_i_reg <= CW'(AW'(p_reg - AW'(1)));
                            fp_second_reg <= 1'b1;
                            p_reg <= '0;
                        end
                        else
                        begin
                            if (!(pos_i_reg < CW'(AW'(p_reg - AW'(1))))) stable_reg <= 1'b0;
                            if (CW'(j_reg) + CW'(1) == n_reg)
                            begin
                                i_reg <= i_reg + AW'(1); ph_reg <= '0;
                            end
                            else
                            begin
                                j_reg <= j_reg + AW'(1); ph_reg <= 2'd1;
                            end
                            state_reg <= S_CKI;
                        end
                    end
                    else p_reg <= p_reg + AW'(1);
                end
                S_EMIT:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (!out_valid)
                    begin
                        out_valid <= 1'b1;
                        out_data.out_suit <= s_rdata[15:8];
                        out_data.out_value <= s_rdata[7:0];
                        out_data.is_stable <= stable_reg;
                        out_data.last_out <= (CW'(p_reg) + CW'(1) == n_reg);
                    end
                    else if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (CW'(p_reg) + CW'(1) == n_reg)
                        begin
                            cnt_reg <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            p_reg <= p_reg + AW'(1);
                            state_reg <= S_EMIT;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

`ifndef SYNTH
    a_no_in_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input open during emission");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MaxCards)) else $error("card count overflow");
`endif
endmodule

@@ design/csort_ram.sv @@
// generic single-port-write ram with registered read
module csort_ram #(
    parameter int Width = 16,
    parameter int Depth = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
